// ===== hw/rtl/adsr_pkg.sv =====
// adsr_pkg: shared types, constants and codes for the adsr envelope core
// no dependencies; imported by every module of the block
`default_nettype none

package adsr_pkg;

  localparam int LVL_W        = 31;
  localparam int FRAC_BITS    = 30;
  localparam int COUNT_BITS   = 10;
  localparam int PROD_W       = 2 * LVL_W;
  localparam int STEP_PROD_W  = LVL_W + COUNT_BITS;
  localparam int SUM_W        = STEP_PROD_W + 1;
  localparam int CFG_IDX_W    = 3;

  localparam logic [LVL_W-1:0] ONE_LVL   = LVL_W'(64'd1 << FRAC_BITS);
  localparam logic [LVL_W-1:0] QR_RATE   =
    LVL_W'(((64'd3 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [LVL_W-1:0] SUS_FLOOR =
    LVL_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_TRIGGER = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_QUICK   = 2'd3;

  localparam logic [1:0] ST_ATTACK  = 2'd0;
  localparam logic [1:0] ST_DECAY   = 2'd1;
  localparam logic [1:0] ST_SUSTAIN = 2'd2;
  localparam logic [1:0] ST_RELEASE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = CFG_IDX_W'(3);

  typedef struct packed {
    logic [1:0]            opcode;
    logic [COUNT_BITS-1:0] sample_count;
  } item_t;

  typedef struct packed {
    logic [LVL_W-1:0] gain;
    logic [1:0]       stage;
    logic             done_res;
  } result_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL_STEP,
    SEQ_ACCUM,
    SEQ_MUL_SCALE,
    SEQ_COMMIT
  } seq_state_t;

  typedef struct packed {
    logic idle;
    logic mul_en;
    logic sel_scale;
    logic acc_en;
    logic commit;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/adsr_mul.sv =====
// adsr_mul: shared 31x31 unsigned multiplier with registered product
// depends on adsr_pkg
`default_nettype none

module adsr_mul
  import adsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [LVL_W-1:0]  a,
  input  wire logic [LVL_W-1:0]  b,
  output logic      [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_seq.sv =====
// adsr_seq: sequencer stepping one transaction through the shared multiplier
// depends on adsr_pkg
`default_nettype none

module adsr_seq
  import adsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  wire logic out_free,
  output ctrl_t     ctrl
);

  seq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE:      if (item_valid) state_next = SEQ_MUL_STEP;
      SEQ_MUL_STEP:  state_next = SEQ_ACCUM;
      SEQ_ACCUM:     state_next = SEQ_MUL_SCALE;
      SEQ_MUL_SCALE: state_next = SEQ_COMMIT;
      SEQ_COMMIT:    if (out_free) state_next = SEQ_IDLE;
      default:       state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.idle      = (state == SEQ_IDLE);
    ctrl.mul_en    = (state == SEQ_MUL_STEP) || (state == SEQ_MUL_SCALE);
    ctrl.sel_scale = (state == SEQ_MUL_SCALE);
    ctrl.acc_en    = (state == SEQ_ACCUM);
    ctrl.commit    = (state == SEQ_COMMIT) && out_free;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_envelope_generator_core.sv =====
// adsr envelope core: an accepted item passes the multiply-step, accumulate, multiply-scale
// and commit states; one item at a time, with two passes through the shared multiplier
// the result register lets the next item be accepted while a result waits
// synchronous active-high reset: stage release, gain and accumulators zero,
// steps zero, sustain level 1.0
// depends on adsr_pkg, adsr_seq, adsr_mul
`default_nettype none

module adsr_envelope_generator_core
  import adsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LVL_W-1:0]     cfg_data
);

  ctrl_t ctrl;
  logic  out_free;
  logic  accept;

  logic [LVL_W-1:0] attack_step, decay_step, sustain_level, release_step;

  logic [1:0]       stage_reg, stage_next;
  logic [LVL_W-1:0] gain_reg, gain_next;
  logic [LVL_W-1:0] attack_acc, attack_acc_next;
  logic [LVL_W-1:0] decay_acc, decay_acc_next;
  logic [LVL_W-1:0] release_acc, release_acc_next;
  logic [LVL_W-1:0] release_start_gain, release_start_gain_next;
  logic             quick_release_flag, quick_release_flag_next;

  item_t            cur;
  logic [LVL_W-1:0] acc_v, stage_val, qr_gain;
  logic [LVL_W-1:0] acc_sel, step_sel, sus_sat;
  logic [SUM_W-1:0] acc_sum;
  logic [LVL_W-1:0] acc_sat;
  logic [STEP_PROD_W-1:0] step_prod;
  logic [LVL_W-1:0] mul_a, mul_b, scaled;
  logic [PROD_W-1:0] prod;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = rst || !ctrl.idle;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = !rst;

  adsr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .out_free   (out_free),
    .ctrl       (ctrl)
  );

  adsr_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= '0;
      decay_step    <= '0;
      sustain_level <= ONE_LVL;
      release_step  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ATTACK_STEP:   attack_step   <= cfg_data;
        CFG_DECAY_STEP:    decay_step    <= cfg_data;
        CFG_SUSTAIN_LEVEL: sustain_level <= cfg_data;
        CFG_RELEASE_STEP:  release_step  <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
  end

  assign sus_sat = (sustain_level > ONE_LVL) ? ONE_LVL : sustain_level;

  always_comb begin
    case (stage_reg)
      ST_ATTACK: begin
        step_sel = attack_step;
        acc_sel  = attack_acc;
      end
      ST_DECAY: begin
        step_sel = decay_step;
        acc_sel  = decay_acc;
      end
      ST_RELEASE: begin
        step_sel = release_step;
        acc_sel  = release_acc;
      end
      default: begin
        step_sel = '0;
        acc_sel  = '0;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    if (!ctrl.sel_scale) begin
      mul_a = quick_release_flag ? QR_RATE : step_sel;
      mul_b = LVL_W'(cur.sample_count);
    end else if (stage_reg == ST_DECAY) begin
      mul_a = ONE_LVL - sus_sat;
      mul_b = stage_val;
    end else begin
      mul_a = release_start_gain;
      mul_b = ONE_LVL - stage_val;
    end
  end

  // accumulate step product and saturate
  assign step_prod = prod[STEP_PROD_W-1:0];
  assign acc_sum   = SUM_W'(acc_sel) + SUM_W'(step_prod);
  assign acc_sat   = (acc_sum > SUM_W'(ONE_LVL)) ? ONE_LVL : acc_sum[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc_v     <= acc_sat;
      stage_val <= (step_sel == '0) ? ONE_LVL : acc_sat;
      qr_gain   <= (STEP_PROD_W'(gain_reg) > step_prod)
                   ? LVL_W'(STEP_PROD_W'(gain_reg) - step_prod) : '0;
    end
  end

  assign scaled = prod[FRAC_BITS +: LVL_W];

  // state update on commit
  always_comb begin
    stage_next              = stage_reg;
    gain_next               = gain_reg;
    attack_acc_next         = attack_acc;
    decay_acc_next          = decay_acc;
    release_acc_next        = release_acc;
    release_start_gain_next = release_start_gain;
    quick_release_flag_next = quick_release_flag;
    case (cur.opcode)
      OP_TICK: begin
        if (quick_release_flag) begin
          gain_next = qr_gain;
        end else begin
          case (stage_reg)
            ST_ATTACK: begin
              attack_acc_next = acc_v;
              if (stage_val >= ONE_LVL) begin
                gain_next  = ONE_LVL;
                stage_next = ST_DECAY;
              end else begin
                gain_next = stage_val;
              end
            end
            ST_DECAY: begin
              decay_acc_next = acc_v;
              if ((ONE_LVL - scaled) <= sus_sat) begin
                gain_next  = sus_sat;
                stage_next = ST_SUSTAIN;
              end else begin
                gain_next = ONE_LVL - scaled;
              end
            end
            ST_SUSTAIN: begin
              gain_next = (sus_sat > SUS_FLOOR) ? sus_sat : SUS_FLOOR;
            end
            default: begin
              release_acc_next = acc_v;
              gain_next        = scaled;
            end
          endcase
        end
      end
      OP_TRIGGER: begin
        stage_next              = ST_ATTACK;
        gain_next               = '0;
        attack_acc_next         = '0;
        decay_acc_next          = '0;
        release_acc_next        = '0;
        quick_release_flag_next = 1'b0;
      end
      OP_RELEASE: begin
        stage_next              = ST_RELEASE;
        release_start_gain_next = gain_reg;
      end
      default: begin
        quick_release_flag_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg          <= ST_RELEASE;
      gain_reg           <= '0;
      attack_acc         <= '0;
      decay_acc          <= '0;
      release_acc        <= '0;
      release_start_gain <= '0;
      quick_release_flag <= 1'b0;
    end else if (ctrl.commit) begin
      stage_reg          <= stage_next;
      gain_reg           <= gain_next;
      attack_acc         <= attack_acc_next;
      decay_acc          <= decay_acc_next;
      release_acc        <= release_acc_next;
      release_start_gain <= release_start_gain_next;
      quick_release_flag <= quick_release_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      result.gain     <= gain_next;
      result.stage    <= stage_next;
      result.done_res <= (gain_next == '0);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_chk.sv =====
// adsr_chk: port-level checks for the adsr envelope core, bound to the top level
// depends on adsr_pkg and adsr_envelope_generator_core
`default_nettype none

module adsr_chk
  import adsr_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_stall,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // a held result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a held result does not change
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  // done flag tracks zero gain
  a_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.done_res == (result.gain == '0)))
    else $error("done flag disagrees with gain");

  // gain never exceeds unity
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.gain <= ONE_LVL))
    else $error("gain above 1.0");

  // one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second transaction accepted while busy");

endmodule

bind adsr_envelope_generator_core adsr_chk u_adsr_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

// ===== tb/tb_adsr_envelope_generator_core.sv =====
// self-checking testbench for adsr_envelope_generator_core: a bit-accurate envelope
// tracker predicts every result, tasks drive items and register writes, stalls are random
// depends on adsr_pkg and the core rtl

import adsr_pkg::*;

class envelope_book;
  bit [63:0]  attack_step, decay_step, sustain_level, release_step;
  logic [1:0] stage;
  bit [63:0]  gain, attack_acc, decay_acc, release_acc, latched_gain;
  bit         quick;
  result_t    expected_q[$];
  int         errors;

  function new();
    attack_step   = 0;
    decay_step    = 0;
    sustain_level = 64'(ONE_LVL);
    release_step  = 0;
    stage         = ST_RELEASE;
    gain          = 0;
    attack_acc    = 0;
    decay_acc     = 0;
    release_acc   = 0;
    latched_gain  = 0;
    quick         = 1'b0;
    errors        = 0;
  endfunction

  task report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function int pending_count();
    return expected_q.size();
  endfunction

  function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] val);
    case (idx)
      CFG_ATTACK_STEP:   attack_step = 64'(val);
      CFG_DECAY_STEP:    decay_step = 64'(val);
      CFG_SUSTAIN_LEVEL: sustain_level = 64'(val);
      CFG_RELEASE_STEP:  release_step = 64'(val);
      default: ;
    endcase
  endfunction

  function bit [63:0] frac_mul(bit [63:0] a, bit [63:0] b);
    return (a * b) >> FRAC_BITS;
  endfunction

  function bit [63:0] advance_acc(inout bit [63:0] acc, input bit [63:0] stp,
                                  input bit [63:0] n);
    bit [63:0] v;
    v = acc + stp * n;
    if (v > 64'(ONE_LVL)) v = 64'(ONE_LVL);
    acc = v;
    return (stp == 0) ? 64'(ONE_LVL) : v;
  endfunction

  function void tick(bit [63:0] n);
    bit [63:0] one, s, v, d;
    one = 64'(ONE_LVL);
    s = (sustain_level > one) ? one : sustain_level;
    if (quick) begin
      d = 64'(QR_RATE) * n;
      gain = (gain > d) ? gain - d : 64'd0;
      return;
    end
    case (stage)
      ST_ATTACK: begin
        gain = advance_acc(attack_acc, attack_step, n);
        if (gain >= one) begin
          gain = one;
          stage = ST_DECAY;
        end
      end
      ST_DECAY: begin
        v = advance_acc(decay_acc, decay_step, n);
        gain = one - frac_mul(one - s, v);
        if (gain <= s) begin
          gain = s;
          stage = ST_SUSTAIN;
        end
      end
      ST_SUSTAIN: gain = (s > 64'(SUS_FLOOR)) ? s : 64'(SUS_FLOOR);
      default: begin
        v = advance_acc(release_acc, release_step, n);
        gain = frac_mul(latched_gain, one - v);
      end
    endcase
  endfunction

  function void note_item(item_t it);
    result_t r;
    case (it.opcode)
      OP_TICK: tick(64'(it.sample_count));
      OP_TRIGGER: begin
        stage = ST_ATTACK;
        gain = 0;
        attack_acc = 0;
        decay_acc = 0;
        release_acc = 0;
        quick = 1'b0;
      end
      OP_RELEASE: begin
        stage = ST_RELEASE;
        latched_gain = gain;
      end
      default: quick = 1'b1;
    endcase
    r.gain = gain[LVL_W-1:0];
    r.stage = stage;
    r.done_res = (gain == 0);
    expected_q.push_back(r);
  endfunction

  task check_result(result_t got);
    result_t exp;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %p", got));
      return;
    end
    exp = expected_q.pop_front();
    if (got.gain !== exp.gain)
      report_mismatch($sformatf("gain got %0d exp %0d", got.gain, exp.gain));
    if (got.stage !== exp.stage)
      report_mismatch($sformatf("stage got %0d exp %0d", got.stage, exp.stage));
    if (got.done_res !== exp.done_res)
      report_mismatch($sformatf("done got %0d exp %0d", got.done_res, exp.done_res));
  endtask
endclass

module tb_adsr_envelope_generator_core;
  import adsr_pkg::*;

  localparam int DIRECTED_ITEMS = 26;
  localparam int RANDOM_ITEMS   = 800;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 400000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LVL_W-1:0]     cfg_data = '0;

  envelope_book book = new();
  int items_sent = 0;
  int cycle_count = 0;
  bit tx_gapless = 1'b0;
  bit rx_gapless = 1'b0;
  bit hold_pending = 1'b0;

  adsr_envelope_generator_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) book.check_result(result);
  end

  // receiver: random stall before each transaction unless gapless, one long hold on request
  initial begin
    int k;
    wait (rst == 1'b0);
    forever begin
      if (hold_pending) k = HOLD_CYCLES;
      else if (rx_gapless) k = 0;
      else k = $urandom_range(0, 10);
      hold_pending = 1'b0;
      if (k > 0) begin
        result_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  task automatic send_item(item_t it);
    int gap;
    gap = tx_gapless ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    book.note_item(it);
    items_sent++;
  endtask

  task automatic send_op(logic [1:0] op, logic [COUNT_BITS-1:0] n);
    item_t it;
    it.opcode = op;
    it.sample_count = n;
    send_item(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    book.apply_reg(idx, val);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (book.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COUNT_BITS-1:0] rand_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return COUNT_BITS'($urandom_range(0, (1 << COUNT_BITS) - 1));
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] pick_step();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return ONE_LVL;
      3: return LVL_W'($urandom);
      4: return LVL_W'($urandom_range(1, 1023));
      default: return LVL_W'($urandom_range(1 << 16, 1 << 20));
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] pick_sustain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ONE_LVL;
      3: return LVL_W'($urandom_range(0, SUS_FLOOR));
      default: return LVL_W'($urandom_range(0, ONE_LVL));
    endcase
  endfunction

  task automatic program_envelope();
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(4, 7)), LVL_W'($urandom));
    write_reg(CFG_ATTACK_STEP, pick_step());
    write_reg(CFG_DECAY_STEP, pick_step());
    write_reg(CFG_SUSTAIN_LEVEL, pick_sustain());
    write_reg(CFG_RELEASE_STEP, pick_step());
    cfg_valid <= 1'b0;
  endtask

  task automatic play_note();
    send_op(OP_TRIGGER, rand_count());
    repeat ($urandom_range(2, 30)) begin
      if ($urandom_range(0, 11) == 0) send_op(2'($urandom_range(0, 3)), rand_count());
      else send_op(OP_TICK, rand_count());
    end
    case ($urandom_range(0, 3))
      0: send_op(OP_RELEASE, rand_count());
      1: send_op(OP_QUICK, rand_count());
      2: begin
        send_op(OP_RELEASE, rand_count());
        repeat ($urandom_range(0, 6)) send_op(OP_TICK, rand_count());
        send_op(OP_QUICK, rand_count());
      end
      default: begin
        send_op(OP_RELEASE, rand_count());
        repeat ($urandom_range(0, 6)) send_op(OP_TICK, rand_count());
        send_op(OP_RELEASE, rand_count());
      end
    endcase
    repeat ($urandom_range(1, 12)) send_op(OP_TICK, rand_count());
  endtask

  initial begin
    int phase;
    phase = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: every step instant, sustain at full scale
    send_op(OP_TICK, '0);
    send_op(OP_TICK, '1);
    send_op(OP_RELEASE, '1);
    send_op(OP_TRIGGER, '0);
    send_op(OP_TICK, 10'd1);
    send_op(OP_TICK, '0);
    send_op(OP_TICK, 10'd7);
    send_op(OP_RELEASE, '0);
    send_op(OP_TICK, 10'd1);
    send_op(OP_QUICK, '1);
    send_op(OP_TICK, 10'd3);

    // zero sustain hits the floor, decay step above full scale saturates
    wait_idle();
    write_reg(CFG_IDX_W'(7), '1);
    write_reg(CFG_ATTACK_STEP, ONE_LVL);
    write_reg(CFG_DECAY_STEP, '1);
    write_reg(CFG_SUSTAIN_LEVEL, '0);
    write_reg(CFG_RELEASE_STEP, LVL_W'(1));
    cfg_valid <= 1'b0;
    send_op(OP_TRIGGER, '1);
    send_op(OP_TICK, 10'd1);
    send_op(OP_TICK, '1);
    send_op(OP_TICK, 10'd2);
    send_op(OP_RELEASE, '0);
    send_op(OP_TICK, '1);
    send_op(OP_QUICK, '0);
    send_op(OP_TICK, '1);
    send_op(OP_RELEASE, '1);

    // sustain above full scale, zero-sample tick in attack
    wait_idle();
    write_reg(CFG_SUSTAIN_LEVEL, '1);
    write_reg(CFG_ATTACK_STEP, '1);
    write_reg(CFG_DECAY_STEP, LVL_W'(1));
    write_reg(CFG_RELEASE_STEP, '0);
    cfg_valid <= 1'b0;
    send_op(OP_TRIGGER, '0);
    send_op(OP_TICK, '0);
    send_op(OP_TICK, 10'd1);
    send_op(OP_TICK, 10'd5);
    send_op(OP_QUICK, '0);
    send_op(OP_TICK, 10'd3);

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      phase++;
      wait_idle();
      program_envelope();
      tx_gapless = ($urandom_range(0, 3) == 0);
      rx_gapless = ($urandom_range(0, 3) == 0);
      if (phase == 4) begin
        tx_gapless = 1'b1;
        rx_gapless = 1'b0;
        hold_pending = 1'b1;
      end
      repeat ($urandom_range(1, 3)) play_note();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
